>>> rtl/core/logrid_pkg.sv
// Package for the label overlap occupancy grid: geometry constants, register
// indices and reset values, result codes, job kinds and back-end states. No dependencies.
`default_nettype none
package logrid_pkg;

	localparam int MAX_COLS_DEF       = 256;
	localparam int MAX_ROWS_DEF       = 256;
	localparam int MARK_HALF_ROWS_DEF = 2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALL_NAMES     = 2'd2;

	localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd640;
	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;

	typedef enum logic [2:0] {
		OUT_PLACED  = 3'd0,
		OUT_BYPASS  = 3'd1,
		OUT_OFFGRID = 3'd2,
		OUT_OVERLAP = 3'd3,
		OUT_CLEARED = 3'd4
	} outcome_t;

	// Kind of work that the front hands to the back.
	typedef enum logic [1:0] {
		JOB_PLACE,
		JOB_CLEAR,
		JOB_DONE
	} job_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CHECK,
		BK_CHECK_WAIT,
		BK_MARK_RD,
		BK_MARK,
		BK_CLEAR,
		BK_REPLY
	} back_state_t;

endpackage
`default_nettype wire

>>> rtl/core/logrid_front.sv
// Front part: classifies incoming transactions into grid jobs.
// Depends on logrid_pkg.
`default_nettype none
module logrid_front #(
	parameter int MAX_COLS = logrid_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = logrid_pkg::MAX_ROWS_DEF,
	parameter int MARK_HALF_ROWS = logrid_pkg::MARK_HALF_ROWS_DEF,
	localparam int CW = $clog2(MAX_COLS),
	localparam int RW = $clog2(MAX_ROWS)
) (
	input  wire logic                   command,
	input  wire logic signed [11:0]     pos_x,
	input  wire logic signed [11:0]     pos_y,
	input  wire logic [7:0]             label_length,
	input  wire logic [10:0]            screen_width,
	input  wire logic [10:0]            screen_height,
	input  wire logic                   all_names,
	output logic [1:0]                  kind,
	output logic [2:0]                  outcome,
	output logic [CW-1:0]               col_lo,
	output logic [CW-1:0]               col_hi,
	output logic [RW-1:0]               row_chk,
	output logic [RW-1:0]               row_top,
	output logic [RW-1:0]               row_bot
);
	logic signed [13:0] sx, sy;
	logic [10:0] ncols_raw, nrows_raw;
	logic [11:0] ncols, nrows;
	logic [11:0] cx, cy;
	logic [12:0] span_end;
	logic [12:0] top_w, bot_w;
	logic off;

	always_comb begin
		ncols_raw = {2'b0, screen_width[10:2]};
		nrows_raw = {2'b0, screen_height[10:2]};
		ncols = (ncols_raw > 11'(MAX_COLS)) ? 12'(MAX_COLS) : {1'b0, ncols_raw};
		nrows = (nrows_raw > 11'(MAX_ROWS)) ? 12'(MAX_ROWS) : {1'b0, nrows_raw};
		sx = 14'(pos_x) + 14'(signed'({3'b0, screen_width[10:1]}));
		sy = 14'(pos_y) + 14'(signed'({3'b0, screen_height[10:1]}));
		cx = 12'(sx[13:2]);
		cy = 12'(sy[13:2]);
		off = sx[13] || sy[13] || (cx >= ncols) || (cy >= nrows);
		span_end = 13'(cx) + 13'({label_length, 1'b0});
		if (span_end >= 13'(ncols))
			span_end = 13'(ncols) - 13'd1;
		top_w = (13'(cy) >= 13'(MARK_HALF_ROWS)) ? 13'(cy) - 13'(MARK_HALF_ROWS) : 13'd0;
		bot_w = 13'(cy) + 13'(MARK_HALF_ROWS);
		if (bot_w >= 13'(nrows))
			bot_w = 13'(nrows) - 13'd1;
		col_lo  = cx[CW-1:0];
		col_hi  = span_end[CW-1:0];
		row_chk = cy[RW-1:0];
		row_top = top_w[RW-1:0];
		row_bot = bot_w[RW-1:0];
		priority if (command) begin
			kind = logrid_pkg::JOB_CLEAR;
			outcome = logrid_pkg::OUT_CLEARED;
		end else if (all_names) begin
			kind = logrid_pkg::JOB_DONE;
			outcome = logrid_pkg::OUT_BYPASS;
		end else if (off) begin
			kind = logrid_pkg::JOB_DONE;
			outcome = logrid_pkg::OUT_OFFGRID;
		end else begin
			kind = logrid_pkg::JOB_PLACE;
			outcome = logrid_pkg::OUT_PLACED;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/logrid_back.sv
// Back part: walks the occupancy memory one 64-bit word at a time to check,
// mark or clear. Depends on logrid_pkg.
`default_nettype none
module logrid_back #(
	parameter int MAX_COLS = logrid_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = logrid_pkg::MAX_ROWS_DEF,
	localparam int CW = $clog2(MAX_COLS),
	localparam int RW = $clog2(MAX_ROWS),
	localparam int WPR = (MAX_COLS + 63) / 64,
	localparam int WW = (WPR > 1) ? $clog2(WPR) : 1,
	localparam int DEPTH = MAX_ROWS * WPR,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire logic [1:0]    kind,
	input  wire logic [2:0]    outcome_in,
	input  wire logic [CW-1:0] col_lo,
	input  wire logic [CW-1:0] col_hi,
	input  wire logic [RW-1:0] row_chk,
	input  wire logic [RW-1:0] row_top,
	input  wire logic [RW-1:0] row_bot,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [2:0]         res_outcome
);
	logic [63:0] mem [DEPTH];
	logic [63:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [63:0] wr_data;
	logic wr_en;

	logrid_pkg::back_state_t state_q, state_d;
	logic          init_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [RW-1:0] rtop_q, rbot_q, row_q;
	logic [WW-1:0] w_q;
	logic [AW:0]   clr_q;
	logic [2:0]    out_q;
	logic [WW-1:0] w_lo, w_hi;
	logic [63:0]   mask;
	logic [AW-1:0] cur_addr;

	assign w_lo = WW'(lo_q >> 6);
	assign w_hi = WW'(hi_q >> 6);
	assign cur_addr = AW'(32'(row_q) * WPR + 32'(w_q));

	// Bit mask of the span inside the current word.
	always_comb begin
		logic [CW+1:0] base;
		logic [CW+1:0] c;
		base = (CW+2)'(w_q) << 6;
		for (int b = 0; b < 64; b++) begin
			c = base + (CW+2)'(b);
			mask[b] = (c >= (CW+2)'(lo_q)) && (c <= (CW+2)'(hi_q));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			logrid_pkg::BK_IDLE:
				if (job_valid) begin
					unique case (kind)
						logrid_pkg::JOB_PLACE: state_d = logrid_pkg::BK_CHECK;
						logrid_pkg::JOB_CLEAR: state_d = logrid_pkg::BK_CLEAR;
						default:               state_d = logrid_pkg::BK_REPLY;
					endcase
				end
			logrid_pkg::BK_CHECK:      state_d = logrid_pkg::BK_CHECK_WAIT;
			logrid_pkg::BK_CHECK_WAIT:
				if ((rd_q & mask) != '0)
					state_d = logrid_pkg::BK_REPLY;
				else if (w_q == w_hi)
					state_d = logrid_pkg::BK_MARK_RD;
				else
					state_d = logrid_pkg::BK_CHECK;
			logrid_pkg::BK_MARK_RD:    state_d = logrid_pkg::BK_MARK;
			logrid_pkg::BK_MARK:
				if (row_q == rbot_q && w_q == w_hi)
					state_d = logrid_pkg::BK_REPLY;
				else
					state_d = logrid_pkg::BK_MARK_RD;
			logrid_pkg::BK_CLEAR:
				if (clr_q == (AW+1)'(DEPTH - 1))
					state_d = init_q ? logrid_pkg::BK_IDLE : logrid_pkg::BK_REPLY;
			logrid_pkg::BK_REPLY:
				if (res_ready)
					state_d = logrid_pkg::BK_IDLE;
			default: state_d = logrid_pkg::BK_IDLE;
		endcase
	end

	// MARK_RD reads a word and MARK writes it back with the span bits set.
	always_comb begin
		job_ready = (state_q == logrid_pkg::BK_IDLE);
		res_valid = (state_q == logrid_pkg::BK_REPLY);
		res_outcome = out_q;
		rd_addr = cur_addr;
		wr_en = 1'b0;
		wr_addr = cur_addr;
		wr_data = rd_q | mask;
		unique case (state_q)
			logrid_pkg::BK_MARK: wr_en = 1'b1;
			logrid_pkg::BK_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q[AW-1:0];
				wr_data = '0;
			end
			default: ;
		endcase
	end

	// After reset the back end runs one clearing pass over the memory
	// before it takes its first job; that pass gives no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= logrid_pkg::BK_CLEAR;
			init_q <= 1'b1;
			out_q <= logrid_pkg::OUT_PLACED;
			clr_q <= '0;
			w_q <= '0;
			row_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			rtop_q <= '0;
			rbot_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				logrid_pkg::BK_IDLE:
					if (job_valid) begin
						out_q <= outcome_in;
						lo_q <= col_lo;
						hi_q <= col_hi;
						rtop_q <= row_top;
						rbot_q <= row_bot;
						row_q <= row_chk;
						w_q <= WW'(col_lo >> 6);
						clr_q <= '0;
					end
				logrid_pkg::BK_CHECK_WAIT:
					if ((rd_q & mask) != '0) begin
						out_q <= logrid_pkg::OUT_OVERLAP;
					end else if (w_q == w_hi) begin
						// Check finished: start marking at the top row.
						row_q <= rtop_q;
						w_q <= w_lo;
					end else begin
						w_q <= w_q + WW'(1);
					end
				logrid_pkg::BK_MARK:
					if (w_q == w_hi) begin
						w_q <= w_lo;
						row_q <= row_q + RW'(1);
					end else begin
						w_q <= w_q + WW'(1);
					end
				logrid_pkg::BK_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (state_d != logrid_pkg::BK_CLEAR)
						init_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/label_overlap_occupancy_grid.sv
// Label overlap occupancy grid, top level. Depends on logrid_pkg, logrid_front,
// logrid_back.
// Bypass and off-grid requests pass through the back end without touching the
// grid; a place request checks each 64-column word of its span and, if none
// overlaps, marks the span in up to five rows; a clear writes every grid word.
// One request is in the back end at a time; the word-serial memory port sets the
// rate. Reset returns the registers to their defaults and starts a clearing pass
// over the MAX_ROWS*ceil(MAX_COLS/64) grid words (1024 by default).
`default_nettype none
module label_overlap_occupancy_grid #(
	parameter int MAX_COLS = logrid_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = logrid_pkg::MAX_ROWS_DEF,
	parameter int MARK_HALF_ROWS = logrid_pkg::MARK_HALF_ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              command,
	input  wire logic signed [11:0] pos_x,
	input  wire logic signed [11:0] pos_y,
	input  wire logic [7:0]        label_length,
	output logic                   empty,
	input  wire logic              pop,
	output logic                   plot,
	output logic [2:0]             outcome,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [10:0]       cfg_data
);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [10:0] width_q, height_q;
	logic        all_q;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= logrid_pkg::SCREEN_WIDTH_RST;
			height_q <= logrid_pkg::SCREEN_HEIGHT_RST;
			all_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == logrid_pkg::REG_SCREEN_WIDTH)
				width_q <= cfg_data;
			if (cfg_index == logrid_pkg::REG_SCREEN_HEIGHT)
				height_q <= cfg_data;
			if (cfg_index == logrid_pkg::REG_ALL_NAMES)
				all_q <= cfg_data[0];
		end
	end

	// Front classification, combinational on the input ports.
	logic [1:0] f_kind;
	logic [2:0] f_out;
	logic [CW-1:0] f_lo, f_hi;
	logic [RW-1:0] f_rc, f_rt, f_rb;

	logrid_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
		.MARK_HALF_ROWS(MARK_HALF_ROWS)) u_front (
		.command(command), .pos_x(pos_x), .pos_y(pos_y),
		.label_length(label_length), .screen_width(width_q),
		.screen_height(height_q), .all_names(all_q),
		.kind(f_kind), .outcome(f_out), .col_lo(f_lo), .col_hi(f_hi),
		.row_chk(f_rc), .row_top(f_rt), .row_bot(f_rb)
	);

	// One-entry job register between front and back.
	logic          jv_q;
	logic [1:0]    jk_q;
	logic [2:0]    jo_q;
	logic [CW-1:0] jlo_q, jhi_q;
	logic [RW-1:0] jrc_q, jrt_q, jrb_q;
	logic          b_ready;

	assign full = jv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q <= 1'b0;
		end else if (push && !jv_q) begin
			jv_q <= 1'b1;
		end else if (jv_q && b_ready) begin
			jv_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (push && !jv_q) begin
			jk_q <= f_kind;
			jo_q <= f_out;
			jlo_q <= f_lo;
			jhi_q <= f_hi;
			jrc_q <= f_rc;
			jrt_q <= f_rt;
			jrb_q <= f_rb;
		end
	end

	// Back end result handed to a one-entry output register.
	logic       r_valid, r_ready;
	logic [2:0] r_out;
	logic       ov_q;
	logic [2:0] oo_q;

	logrid_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(jv_q), .job_ready(b_ready),
		.kind(jk_q), .outcome_in(jo_q), .col_lo(jlo_q), .col_hi(jhi_q),
		.row_chk(jrc_q), .row_top(jrt_q), .row_bot(jrb_q),
		.res_valid(r_valid), .res_ready(r_ready), .res_outcome(r_out)
	);

	assign r_ready = !ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			oo_q <= logrid_pkg::OUT_PLACED;
		end else if (r_valid && !ov_q) begin
			ov_q <= 1'b1;
			oo_q <= r_out;
		end else if (ov_q && pop) begin
			ov_q <= 1'b0;
		end
	end

	assign empty = !ov_q;
	assign outcome = oo_q;
	assign plot = (oo_q == logrid_pkg::OUT_PLACED) || (oo_q == logrid_pkg::OUT_BYPASS);
endmodule
`default_nettype wire

>>> rtl/core/logrid_checker.sv
// Port-level checker for the label overlap occupancy grid, bound to the top.
// Depends on logrid_pkg.
`default_nettype none
module logrid_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       plot,
	input wire logic [2:0] outcome
);
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outcome <= logrid_pkg::OUT_CLEARED) else $error("bad outcome");
	a_plot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> plot == (outcome == logrid_pkg::OUT_PLACED ||
		outcome == logrid_pkg::OUT_BYPASS)) else $error("plot mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(outcome))) else $error("result lost");
endmodule
bind label_overlap_occupancy_grid logrid_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.plot(plot), .outcome(outcome)
);
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for label_overlap_occupancy_grid.
// Depends on logrid_pkg and the block's RTL; it reads no files.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import logrid_pkg::*;

	// One label request or grid clear as it appears on the input ports.
	typedef struct {
		logic               cmd;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic [7:0]         len;
	} label_req_t;

	// One decision as it appears on the result ports.
	typedef struct {
		logic     plot;
		outcome_t oc;
	} decision_t;

	localparam int NCOLS = MAX_COLS_DEF;
	localparam int NROWS = MAX_ROWS_DEF;
	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic command = 1'b0;
	logic signed [11:0] pos_x = '0;
	logic signed [11:0] pos_y = '0;
	logic [7:0] label_length = '0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic full, empty, plot, cfg_ready;
	logic [2:0] outcome;

	label_overlap_occupancy_grid i_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .pos_x(pos_x), .pos_y(pos_y), .label_length(label_length),
		.empty(empty), .pop(pop), .plot(plot), .outcome(outcome),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the grid and the registers, used for prediction.
	bit occupied [0:NROWS-1][0:NCOLS-1];
	logic [10:0] shadow_width = SCREEN_WIDTH_RST;
	logic [10:0] shadow_height = SCREEN_HEIGHT_RST;
	logic shadow_all_names = 1'b0;

	label_req_t pending_reqs[$];
	decision_t  expected_decisions[$];

	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_placed = 0;
	int n_overlap = 0;
	int n_offgrid = 0;
	int n_cfg_writes = 0;

	// Maps a signed pixel coordinate onto a grid index; returns -1 when off the grid.
	function automatic int grid_cell(logic signed [11:0] coord, logic [10:0] screen, int limit);
		int sum;
		int n;
		sum = int'(coord) + int'(screen / 2);
		n = int'(screen / 4);
		if (n > limit)
			n = limit;
		if (sum < 0 || sum / 4 >= n)
			return -1;
		return sum / 4;
	endfunction

	// Works out the decision for one request and updates the shadow grid.
	function automatic decision_t decide_label(label_req_t r);
		decision_t d;
		int cols, rows, cx, cy, span, top, bottom;
		bit hit;
		hit = 0;
		if (r.cmd == CMD_CLEAR) begin
			occupied = '{default: '0};
			d.plot = 1'b0;
			d.oc = OUT_CLEARED;
			return d;
		end
		if (shadow_all_names) begin
			d.plot = 1'b1;
			d.oc = OUT_BYPASS;
			return d;
		end
		cols = int'(shadow_width / 4);
		if (cols > NCOLS)
			cols = NCOLS;
		rows = int'(shadow_height / 4);
		if (rows > NROWS)
			rows = NROWS;
		cx = grid_cell(r.x, shadow_width, NCOLS);
		cy = grid_cell(r.y, shadow_height, NROWS);
		if (cx < 0 || cy < 0) begin
			d.plot = 1'b0;
			d.oc = OUT_OFFGRID;
			n_offgrid++;
			return d;
		end
		span = 2 * int'(r.len) + 1;
		if (cx + span >= cols)
			span = cols - cx;
		for (int i = 0; i < span; i++)
			if (occupied[cy][cx + i])
				hit = 1;
		if (hit) begin
			d.plot = 1'b0;
			d.oc = OUT_OVERLAP;
			n_overlap++;
			return d;
		end
		top = (cy >= MARK_HALF_ROWS_DEF) ? cy - MARK_HALF_ROWS_DEF : 0;
		bottom = cy + MARK_HALF_ROWS_DEF;
		if (bottom >= rows)
			bottom = rows - 1;
		for (int row = top; row <= bottom; row++)
			for (int i = 0; i < span; i++)
				occupied[row][cx + i] = 1'b1;
		d.plot = 1'b1;
		d.oc = OUT_PLACED;
		n_placed++;
		return d;
	endfunction

	function automatic label_req_t make_req(logic cmd, int x, int y, int len);
		label_req_t r;
		r.cmd = cmd;
		r.x = 12'(x);
		r.y = 12'(y);
		r.len = 8'(len);
		return r;
	endfunction

	// Random request: mostly on-grid labels with short text so that the grid
	// fills and overlaps occur, with occasional clears and full-range noise.
	function automatic label_req_t random_req();
		int pick, w, h;
		pick = $urandom_range(99);
		w = int'(shadow_width);
		h = int'(shadow_height);
		if (pick < 3)
			return make_req(CMD_CLEAR, $urandom, $urandom, $urandom);
		if (pick < 15)
			return make_req(CMD_PLACE, $urandom, $urandom, $urandom);
		return make_req(CMD_PLACE,
			int'($urandom_range(0, w + 7)) - w / 2 - 4,
			int'($urandom_range(0, h + 7)) - h / 2 - 4,
			(pick < 25) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 6)));
	endfunction

	// Driver: a transaction is accepted at an edge with push high and full low.
	// The receiver hold-off means the sender keeps offering into a full block.
	bit quiet;
	always @(posedge clk) begin
		label_req_t nxt;
		bit drive;
		if (push && !full) begin
			expected_decisions.push_back(decide_label(pending_reqs.pop_front()));
			n_sent++;
		end
		quiet = (n_sent >= 200 && n_sent < 450);
		drive = (pending_reqs.size() != 0) && (quiet || $urandom_range(99) >= 12);
		if (drive) begin
			nxt = pending_reqs[0];
			command <= nxt.cmd;
			pos_x <= nxt.x;
			pos_y <= nxt.y;
			label_length <= nxt.len;
		end
		push <= drive;
	end

	// Long receiver hold-off, counted here, started once mid-run.
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && n_sent >= 700) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	// Monitor: compares each popped result with the oldest prediction.
	always @(posedge clk) begin
		decision_t want;
		if (pop && !empty) begin
			if (expected_decisions.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: result with nothing expected: plot=%0b outcome=%0d",
						plot, outcome);
			end else begin
				want = expected_decisions.pop_front();
				n_checked++;
				if (plot !== want.plot || outcome !== 3'(want.oc)) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result %0d: expected plot=%0b outcome=%0d, %s",
							n_checked, want.plot, want.oc,
							$sformatf("got plot=%0b outcome=%0d", plot, outcome));
				end
			end
		end
		pop <= (hold_left == 0) && (quiet || $urandom_range(99) >= 12);
	end

	// Configuration writes happen only while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCREEN_WIDTH:  shadow_width = val;
			REG_SCREEN_HEIGHT: shadow_height = val;
			REG_ALL_NAMES:     shadow_all_names = val[0];
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_decisions.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_screen(logic [10:0] w, logic [10:0] h, logic all);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_ALL_NAMES, {10'd0, all});
	endtask

	initial begin
		occupied = '{default: '0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at the reset geometry of 160 by 120 cells. The grid
		// starts out empty after reset, so the first label is placed.
		pending_reqs.push_back(make_req(CMD_PLACE, 0, 0, 0));
		pending_reqs.push_back(make_req(CMD_PLACE, 0, 0, 0));      // same spot overlaps
		pending_reqs.push_back(make_req(CMD_PLACE, 0, 8, 0));      // inside marked rows
		pending_reqs.push_back(make_req(CMD_PLACE, -320, -240, 0)); // top-left corner
		pending_reqs.push_back(make_req(CMD_PLACE, 319, 239, 255)); // right edge, bottom
		pending_reqs.push_back(make_req(CMD_PLACE, 320, 0, 0));    // one column past
		pending_reqs.push_back(make_req(CMD_PLACE, 0, 240, 0));    // one row past
		pending_reqs.push_back(make_req(CMD_PLACE, -321, 0, 0));   // negative sum
		pending_reqs.push_back(make_req(CMD_PLACE, 0, -241, 0));
		pending_reqs.push_back(make_req(CMD_PLACE, 2047, 2047, 255));
		pending_reqs.push_back(make_req(CMD_PLACE, -2048, -2048, 0));
		pending_reqs.push_back(make_req(CMD_PLACE, 1365, -1366, 170));
		pending_reqs.push_back(make_req(CMD_PLACE, -100, -240, 3)); // top clamp
		pending_reqs.push_back(make_req(CMD_PLACE, -200, 100, 85));
		pending_reqs.push_back(make_req(CMD_CLEAR, -1, -1, 255));
		pending_reqs.push_back(make_req(CMD_PLACE, 0, 0, 0));      // placed again after clear
		drain();

		// Largest, oversized and smallest geometries, then bypass, with an
		// index that names no register. The resize phases keep the old grid.
		set_screen(11'd1024, 11'd1024, 1'b0);
		repeat (300) pending_reqs.push_back(random_req());
		drain();
		set_screen(11'd2047, 11'd2047, 1'b0);
		repeat (250) pending_reqs.push_back(random_req());
		drain();
		write_reg(2'd3, 11'h7ff);
		set_screen(11'd4, 11'd4, 1'b0);
		repeat (60) pending_reqs.push_back(random_req());
		drain();
		set_screen(11'd3, 11'd2, 1'b0);
		repeat (40) pending_reqs.push_back(random_req());
		drain();
		set_screen(11'd100, 11'd60, 1'b1);
		repeat (100) pending_reqs.push_back(random_req());
		drain();
		set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 1'b0);
		repeat (500) pending_reqs.push_back(random_req());
		drain();
		set_screen(11'($urandom_range(4, 1024)), 11'($urandom_range(4, 1024)), 1'b0);
		repeat (300) pending_reqs.push_back(random_req());
		drain();

		$display("Covered %0d requests, %0d checked results, %0d register writes.",
			n_sent, n_checked, n_cfg_writes);
		$display("Outcomes seen: %0d placed, %0d overlaps, %0d off grid.",
			n_placed, n_overlap, n_offgrid);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("ERROR: timeout with %0d results outstanding", expected_decisions.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/logrid_pkg.sv
rtl/core/logrid_front.sv
rtl/core/logrid_back.sv
rtl/core/label_overlap_occupancy_grid.sv
rtl/core/logrid_checker.sv
verif/tb_top.sv
